FILE: hw/rtl/sha_pkg.sv
// ----------------------------------------------------------------------------
// SHA-256 package
// Shared types and constants for the SHA-256 message hasher.
// ----------------------------------------------------------------------------
package sha_pkg;

  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = 2;

  // One decoded word handed from the front end to the compression engine.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       last;
  } sha_cmd_t;

  localparam logic [31:0] InitHash [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [7:0] PadByte = 8'h80;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

endpackage

FILE: hw/rtl/sha_front.sv
// ----------------------------------------------------------------------------
// SHA-256 front end
// Accepts input words, drops empty ones and queues the rest for the engine.
// ----------------------------------------------------------------------------
module sha_front import sha_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  output logic       stall_o,
  input  logic [7:0] data_byte_i,
  input  logic       has_byte_i,
  input  logic       last_i,
  output logic       cmd_valid_o,
  input  logic       cmd_pop_i,
  output sha_cmd_t   cmd_o
);

  sha_cmd_t             fifo_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_q, rd_q;
  logic [QueuePtrW:0]   cnt_q;
  logic                 push, pop;

  assign stall_o     = (cnt_q == QueuePtrW'(0) + (QueuePtrW+1)'(QueueDepth));
  // Words with neither a byte nor an end mark change nothing and are dropped.
  assign push        = valid_i && !stall_o && (has_byte_i || last_i);
  assign cmd_valid_o = (cnt_q != '0);
  assign pop         = cmd_pop_i && cmd_valid_o;
  assign cmd_o       = fifo_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= wr_q + 1'b1;
      if (pop)  rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + (QueuePtrW+1)'(push) - (QueuePtrW+1)'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) fifo_q[wr_q] <= '{data_byte: data_byte_i, has_byte: has_byte_i, last: last_i};
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (QueuePtrW+1)'(QueueDepth)) else $error("queue overflow");
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0) |-> !pop) else $error("pop from empty queue");
  a_cnt_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> cnt_q == $past(cnt_q) + 1'b1) else $error("count mismatch");

endmodule

FILE: hw/rtl/sha_engine.sv
// ----------------------------------------------------------------------------
// SHA-256 compression engine
// Packs bytes, pads, runs one round per cycle and streams the digest.
// ----------------------------------------------------------------------------
module sha_engine import sha_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cmd_valid_i,
  output logic        cmd_pop_o,
  input  sha_cmd_t    cmd_i,
  output logic        valid_o,
  input  logic        stall_i,
  output logic [31:0] digest_word_o,
  output logic [2:0]  word_index_o,
  output logic        last_word_o
);

  typedef enum logic [2:0] {
    StIdle, StRound, StPad, StLen, StOut
  } state_e;

  state_e       state_q;
  logic [31:0]  hash_q [8];
  logic [31:0]  var_q [8];
  logic [31:0]  win_q [16];
  logic [63:0]  count_q;
  logic [5:0]   round_q;
  logic         cnt_done_q;  // round counter has passed 63
  logic         fin_q;       // current block ends the message
  logic         two_q;       // padding needs a second block
  logic         pad_q;       // padding is still owed once this block is done
  logic [2:0]   oidx_q;
  logic         ovalid_q;

  logic [5:0]   pos;
  logic [31:0]  wt, t1, t2, g0, g1, s1, s0, ch, maj;

  assign pos = count_q[5:0];

  // Message schedule in place: win_q[0] always holds the current W.
  assign g0 = rotr(win_q[1], 7) ^ rotr(win_q[1], 18) ^ (win_q[1] >> 3);
  assign g1 = rotr(win_q[14], 17) ^ rotr(win_q[14], 19) ^ (win_q[14] >> 10);
  assign wt = win_q[0];
  assign s1 = rotr(var_q[4], 6) ^ rotr(var_q[4], 11) ^ rotr(var_q[4], 25);
  assign ch = (var_q[4] & var_q[5]) ^ (~var_q[4] & var_q[6]);
  assign t1 = var_q[7] + s1 + ch + RoundK[round_q] + wt;
  assign s0 = rotr(var_q[0], 2) ^ rotr(var_q[0], 13) ^ rotr(var_q[0], 22);
  assign maj = (var_q[0] & var_q[1]) ^ (var_q[0] & var_q[2]) ^ (var_q[1] & var_q[2]);
  assign t2 = s0 + maj;

  assign cmd_pop_o     = (state_q == StIdle) && cmd_valid_i;
  assign valid_o       = ovalid_q;
  assign digest_word_o = hash_q[0];
  assign word_index_o  = oidx_q;
  assign last_word_o   = (oidx_q == 3'd7);

  function automatic logic [31:0] put(input logic [31:0] w, input logic [1:0] sub,
                                      input logic [7:0] b);
    put = w | ({24'd0, b} << ({3'd0, ~sub} * 5'd8));
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      hash_q     <= InitHash;
      var_q      <= '{default: '0};
      win_q      <= '{default: '0};
      count_q    <= '0;
      round_q    <= '0;
      cnt_done_q <= 1'b0;
      fin_q      <= 1'b0;
      two_q      <= 1'b0;
      pad_q      <= 1'b0;
      oidx_q     <= '0;
      ovalid_q   <= 1'b0;
    end else begin
      unique case (state_q)
        StIdle: begin
          if (cmd_valid_i) begin
            if (cmd_i.has_byte) begin
              win_q[pos[5:2]] <= put(win_q[pos[5:2]], pos[1:0], cmd_i.data_byte);
              count_q <= count_q + 64'd1;
              if (pos == 6'd63) begin
                pad_q   <= cmd_i.last;
                two_q   <= 1'b0;
                var_q   <= hash_q;
                round_q <= '0;
                state_q <= StRound;
              end else if (cmd_i.last) begin
                state_q <= StPad;
              end
            end else begin
              state_q <= StPad;
            end
          end
        end
        StPad: begin
          win_q[pos[5:2]] <= put(win_q[pos[5:2]], pos[1:0], PadByte);
          fin_q   <= 1'b1;
          pad_q   <= 1'b0;
          two_q   <= (pos >= 6'd56);
          var_q   <= hash_q;
          round_q <= '0;
          if (pos < 6'd56) state_q <= StLen;
          else             state_q <= StRound;
        end
        StLen: begin
          win_q[14] <= count_q[60:29];
          win_q[15] <= {count_q[28:0], 3'b000};
          two_q     <= 1'b0;
          var_q     <= hash_q;
          round_q   <= '0;
          state_q   <= StRound;
        end
        StRound: begin
          var_q[7] <= var_q[6];
          var_q[6] <= var_q[5];
          var_q[5] <= var_q[4];
          var_q[4] <= var_q[3] + t1;
          var_q[3] <= var_q[2];
          var_q[2] <= var_q[1];
          var_q[1] <= var_q[0];
          var_q[0] <= t1 + t2;
          round_q  <= round_q + 1'b1;
          cnt_done_q <= (round_q == 6'd63);
          if (round_q == 6'd63) begin
            for (int i = 0; i < 8; i++) hash_q[i] <= hash_q[i] + ((i == 0) ? t1 + t2 :
              (i == 4) ? var_q[3] + t1 : var_q[i-1]);
            win_q <= '{default: '0};
            if (!fin_q)      state_q <= pad_q ? StPad : StIdle;
            else if (two_q)  state_q <= StLen;
            else begin
              state_q  <= StOut;
              oidx_q   <= '0;
              ovalid_q <= 1'b1;
            end
          end else begin
            for (int i = 0; i < 15; i++) win_q[i] <= win_q[i+1];
            win_q[15] <= wt + g0 + win_q[9] + g1;
          end
        end
        StOut: begin
          if (!stall_i) begin
            for (int i = 0; i < 7; i++) hash_q[i] <= hash_q[i+1];
            hash_q[7] <= InitHash[oidx_q];
            oidx_q    <= oidx_q + 1'b1;
            if (oidx_q == 3'd7) begin
              ovalid_q <= 1'b0;
              count_q  <= '0;
              fin_q    <= 1'b0;
              state_q  <= StIdle;
            end
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  a_out_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovalid_q |-> state_q == StOut) else $error("output valid outside output phase");
  a_no_pop_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_o |-> state_q == StIdle) else $error("pop while busy");
  a_round_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StRound && round_q == 6'd63) |=> cnt_done_q) else $error("round count");

endmodule

FILE: hw/rtl/sha256_message_hasher.sv
// ----------------------------------------------------------------------------
// SHA-256 message hasher
// Byte-serial SHA-256 with a front queue and a round-per-cycle engine.
// ----------------------------------------------------------------------------
// A byte that completes a block starts its compression; a last word leads to padding,
// compression of the final block or blocks, and then the digest as 8 words.
// The engine takes no new byte while it compresses a block or streams the digest.
// Reset: asynchronous, active low; hash reloads the initial values, queue empties.
module sha256_message_hasher import sha_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        has_byte_i,
  input  logic        last_i,
  output logic        valid_o,
  input  logic        stall_i,
  output logic [31:0] digest_word_o,
  output logic [2:0]  word_index_o,
  output logic        last_word_o
);

  // The front end buffers up to four words so the sender keeps going while the
  // engine is busy compressing a block, until the queue is full and stall_o rises.
  logic     cmd_valid, cmd_pop;
  sha_cmd_t cmd;

  sha_front u_front (
    .clk_i, .rst_ni, .valid_i, .stall_o, .data_byte_i, .has_byte_i, .last_i,
    .cmd_valid_o(cmd_valid), .cmd_pop_i(cmd_pop), .cmd_o(cmd)
  );

  // The engine holds each digest word in its output register until taken.
  sha_engine u_engine (
    .clk_i, .rst_ni, .cmd_valid_i(cmd_valid), .cmd_pop_o(cmd_pop), .cmd_i(cmd),
    .valid_o, .stall_i, .digest_word_o, .word_index_o, .last_word_o
  );

endmodule
